>>> rtl/rtk_pkg.sv
package rtk_pkg;

  // Depth of the running list and width of a stored value.
  localparam int MAX_TOP    = 8;
  localparam int VALUE_BITS = 32;

  // Fixed field widths of the channels.
  localparam int IN_W  = 32;
  localparam int OUT_W = 32;
  localparam int CFG_W = 4;

  // Most values reported per row, and the width of a count up to it.
  localparam int RESULT_CAP = (MAX_TOP < 8) ? MAX_TOP : 8;
  localparam int CNT_W      = $clog2(RESULT_CAP + 1);

  // Reset value of the count register.
  localparam logic [CFG_W-1:0] TOP_COUNT_RESET = 4'd5;

  // Row snapshot queue between the front and the back.
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [MAX_TOP-1:0][VALUE_BITS-1:0] list_t;

  typedef struct packed {
    logic [IN_W-1:0] sample_value;
    logic            row_end;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] ranked_value;
    logic             run_last;
  } out_item_t;

  // One finished row: its sorted list and how many entries to report.
  typedef struct packed {
    list_t            vals;
    logic [CNT_W-1:0] count;
  } snap_t;

endpackage

>>> rtl/rtk_front.sv
module rtk_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  rtk_pkg::in_item_t in_item,
  input  logic              cfg_we,
  input  logic [rtk_pkg::CFG_W-1:0] cfg_wdata,
  output logic              snap_push,
  output rtk_pkg::snap_t    snap_data,
  input  logic              snap_full
);
  import rtk_pkg::*;

  list_t            list_r, list_nxt;
  list_t            ins_list;
  logic [CFG_W-1:0] top_count_r;
  logic [CNT_W-1:0] eff_count;
  logic [MAX_TOP-1:0] ge;
  value_t           val;
  logic             accept;
  logic             prev_ge;
  value_t           prev_val;

  // An item is taken whenever the snapshot queue has room.
  assign in_full = snap_full;
  assign accept  = in_push && !snap_full;
  assign val     = VALUE_BITS'(in_item.sample_value);

  // Parallel compare-insert: the new value goes after every entry that is
  // greater or equal, and the entries below it move down one place.
  always_comb begin
    prev_ge  = 1'b1;
    prev_val = '0;
    for (int i = 0; i < MAX_TOP; i++) begin
      ge[i] = (list_r[i] >= val);
      if (ge[i]) begin
        ins_list[i] = list_r[i];
      end else if (prev_ge) begin
        ins_list[i] = val;
      end else begin
        ins_list[i] = prev_val;
      end
      prev_ge  = ge[i];
      prev_val = list_r[i];
    end
  end

  // Reported count, with zero read as one and large codes saturated.
  always_comb begin
    priority if (top_count_r == '0) begin
      eff_count = CNT_W'(1);
    end else if (top_count_r > CFG_W'(RESULT_CAP)) begin
      eff_count = CNT_W'(RESULT_CAP);
    end else begin
      eff_count = CNT_W'(top_count_r);
    end
  end

  // A row end hands the updated list to the queue and clears the list.
  always_comb begin
    list_nxt        = list_r;
    snap_push       = 1'b0;
    snap_data.vals  = ins_list;
    snap_data.count = eff_count;
    if (accept) begin
      if (in_item.row_end) begin
        list_nxt  = '0;
        snap_push = 1'b1;
      end else begin
        list_nxt = ins_list;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_r      <= '0;
      top_count_r <= TOP_COUNT_RESET;
    end else begin
      list_r <= list_nxt;
      if (cfg_we) begin
        top_count_r <= cfg_wdata;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // The list stays in descending order.
  generate
    for (genvar g = 1; g < MAX_TOP; g++) begin : g_order
      a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        list_r[g-1] >= list_r[g])
        else $error("running list out of order");
    end
  endgenerate

  // A row end leaves an empty list behind.
  a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.row_end) |=> (list_r == '0))
    else $error("list not cleared after row end");

  // A finished row is handed over only while the queue has room.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    snap_push |-> !snap_full)
    else $error("row handed to a full queue");
`endif

endmodule

>>> rtl/rtk_snap_fifo.sv
module rtk_snap_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rtk_pkg::snap_t wr_data,
  output logic           full,
  output logic           valid,
  input  logic           pop,
  output rtk_pkg::snap_t rd_data
);
  import rtk_pkg::*;

  snap_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;
  logic                  do_push, do_pop;

  assign full    = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign valid   = (count_r != '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("snapshot queue overfilled");

  a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("snapshot pushed into a full queue");

  a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !valid))
    else $error("snapshot popped from an empty queue");
`endif

endmodule

>>> rtl/rtk_back.sv
module rtk_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               snap_valid,
  input  rtk_pkg::snap_t     snap_data,
  output logic               snap_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output rtk_pkg::out_item_t out_item
);
  import rtk_pkg::*;

  list_t            vals_r, vals_nxt;
  logic [CNT_W-1:0] remain_r, remain_nxt;
  logic             busy_r, busy_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;
  logic             can_load;
  logic             emit;
  logic             final_beat;

  // The output register may be refilled when it is empty or being taken.
  assign can_load   = !out_valid_r || out_pop;
  assign emit       = busy_r && can_load;
  assign final_beat = (remain_r == CNT_W'(1));
  assign snap_pop   = snap_valid && (!busy_r || (emit && final_beat));

  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

  // Emit the head of the list each beat and shift the rest up; a new row
  // is loaded as soon as the current one has sent its final beat.
  always_comb begin
    vals_nxt      = vals_r;
    remain_nxt    = remain_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_item_nxt  = out_item_r;
    if (emit) begin
      out_valid_nxt             = 1'b1;
      out_item_nxt.ranked_value = OUT_W'(vals_r[0]);
      out_item_nxt.run_last     = final_beat;
      for (int i = 0; i < MAX_TOP - 1; i++) begin
        vals_nxt[i] = vals_r[i+1];
      end
      vals_nxt[MAX_TOP-1] = '0;
      remain_nxt          = remain_r - 1'b1;
      busy_nxt            = !final_beat;
    end
    if (snap_pop) begin
      vals_nxt   = snap_data.vals;
      remain_nxt = snap_data.count;
      busy_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      remain_r    <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      remain_r    <= remain_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    vals_r     <= vals_nxt;
    out_item_r <= out_item_nxt;
  end

`ifndef NO_ASSERTIONS
  a_busy_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (remain_r != '0))
    else $error("emitter busy with nothing left to send");

  a_remain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    remain_r <= CNT_W'(RESULT_CAP))
    else $error("remaining count above the reporting limit");

  a_row_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && final_beat && !snap_pop) |=> !busy_r)
    else $error("emitter still busy after the final beat of a row");
`endif

endmodule

>>> rtl/row_top_k_selector.sv
// Row top-k selector.
// Input queue port: a beat carries one row element and a row-end flag; it is
// taken at a clock edge where in_push is high and in_full is low. Elements
// of a row are inserted into a sorted list of the MAX_TOP largest values, one
// per cycle while in_full is low: a row streams in at one element per cycle.
// Output queue port: while out_empty is low, out_item holds the next value of
// a finished row, largest first; the row's last reported value has run_last
// set. A beat is taken when out_pop is high and out_empty is low, one per
// cycle at most.
// A finished row goes through the row queue and the emitter's list register
// to the output register. Each row sends top_count beats (zero reads as one,
// codes above eight are held to eight); rows shorter than that are padded
// with zeros. The emitter sends one beat per cycle unless out_pop holds it
// off, and starts the next row right after the last beat of the previous one.
// Stalls: a two-entry queue of finished rows sits between the insertion list
// and the emitter. in_full rises while both entries are in use, which happens
// when rows end faster than their beats are sent, as with rows shorter than
// top_count or a receiver that holds off out_pop.
// Configuration: cfg_we writes cfg_wdata as top_count; reset sets it to five.
// Reset clears the list, the row queue and the output register.
module row_top_k_selector (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  rtk_pkg::in_item_t  in_item,
  output logic               out_empty,
  input  logic               out_pop,
  output rtk_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [rtk_pkg::CFG_W-1:0] cfg_wdata
);
  import rtk_pkg::*;

  logic  snap_push, snap_full, snap_valid, snap_pop;
  snap_t snap_wr, snap_rd;

  rtk_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .snap_push (snap_push),
    .snap_data (snap_wr),
    .snap_full (snap_full)
  );

  rtk_snap_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (snap_push),
    .wr_data (snap_wr),
    .full    (snap_full),
    .valid   (snap_valid),
    .pop     (snap_pop),
    .rd_data (snap_rd)
  );

  rtk_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap_data  (snap_rd),
    .snap_pop   (snap_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_item   (out_item)
  );

endmodule

>>> tb/tb_row_top_k_selector.sv
`timescale 1ns / 1ps

module tb_row_top_k_selector;
  import rtk_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_push = 1'b0;
  logic              in_full;
  in_item_t          in_item = '0;
  logic              out_empty;
  logic              out_pop = 1'b0;
  out_item_t         out_item;
  logic              cfg_we = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  row_top_k_selector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Free-running clock, 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predicted state: the running sorted list and the current count code.
  value_t           best_vals [MAX_TOP];
  logic [CFG_W-1:0] model_top_count;
  out_item_t        ranked_q [$];
  value_t           row_vals [$];

  int error_count = 0;
  bit in_idle_en  = 1'b1;
  bit out_idle_en = 1'b1;
  int hold_req    = 0;

  // Idle length: mostly none or short, now and then a long one.
  function automatic int gap_len(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Insert a value into the descending list; equal values stay ahead of it.
  function automatic void insert_value(input value_t v);
    int pos;
    int i;
    pos = 0;
    while (pos < MAX_TOP && best_vals[pos] >= v) pos++;
    if (pos < MAX_TOP) begin
      for (i = MAX_TOP - 1; i > pos; i--) best_vals[i] = best_vals[i-1];
      best_vals[pos] = v;
    end
  endfunction

  // Work out the beats that one accepted input beat causes.
  function automatic void predict_ranking(input in_item_t it);
    int        k;
    int        i;
    out_item_t r;
    insert_value(it.sample_value);
    if (!it.row_end) return;
    k = int'(model_top_count);
    if (k < 1) k = 1;
    if (k > RESULT_CAP) k = RESULT_CAP;
    for (i = 0; i < k; i++) begin
      r.ranked_value = best_vals[i];
      r.run_last     = (i == k - 1);
      ranked_q.push_back(r);
    end
    for (i = 0; i < MAX_TOP; i++) best_vals[i] = '0;
  endfunction

  function automatic void log_mismatch(input string what, input out_item_t want,
                                       input out_item_t got);
    error_count++;
    if (error_count <= 10) begin
      $display("%s: expected value %h last %b, got value %h last %b", what,
               want.ranked_value, want.run_last, got.ranked_value, got.run_last);
    end
  endfunction

  // Offer one element and hold it until it is taken, then idle a while.
  task automatic send_item(input value_t v, input logic last);
    in_item_t it;
    int       g;
    it.sample_value = v;
    it.row_end      = last;
    @(negedge clk);
    in_push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_ranking(it);
    g = gap_len(in_idle_en);
    if (g > 0) begin
      @(negedge clk);
      in_push <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  // Send the elements in row_vals as one row and empty the buffer.
  task automatic send_row_vals();
    int j;
    for (j = 0; j < row_vals.size(); j++) begin
      send_item(row_vals[j], j == row_vals.size() - 1);
    end
    row_vals.delete();
  endtask

  // Stop sending and wait until every predicted beat has been taken.
  task automatic wait_all_results();
    @(negedge clk);
    in_push <= 1'b0;
    while (ranked_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Count updates are made only once the block has gone quiet.
  task automatic write_top_count(input logic [CFG_W-1:0] code);
    wait_all_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= code;
    @(negedge clk);
    cfg_we <= 1'b0;
    model_top_count = code;
  endtask

  // Row element mix: wide random, small, the two extremes, ties, near-top and right-shifted random.
  function automatic value_t pick_value(input value_t prev);
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom;
    if (r < 55) return $urandom_range(0, 15);
    if (r < 63) return '0;
    if (r < 71) return '1;
    if (r < 83) return prev;
    if (r < 91) return 32'hFFFF_FF00 | $urandom_range(0, 255);
    return $urandom >> $urandom_range(1, 31);
  endfunction

  // Random rows, mostly of moderate length, the last one closing the phase.
  task automatic send_random_rows(input int n_items);
    int     left;
    int     len;
    int     r;
    int     j;
    value_t v;
    value_t prev;
    left = n_items;
    prev = '0;
    while (left > 0) begin
      r = $urandom_range(0, 99);
      if (r < 10) len = 1;
      else if (r < 85) len = $urandom_range(2, 10);
      else len = $urandom_range(11, 24);
      if (len > left) len = left;
      for (j = 0; j < len; j++) begin
        v = pick_value(prev);
        send_item(v, j == len - 1);
        prev = v;
      end
      left -= len;
    end
  endtask

  // Extremes, ties, a row that fills the list and short rows, at count 5.
  task automatic test_directed_rows();
    row_vals = {32'h0000_0000};
    send_row_vals();
    row_vals = {32'hFFFF_FFFF};
    send_row_vals();
    row_vals = {32'd3, 32'hFFFF_FFFF, 32'd7, 32'd7, 32'd0, 32'hFFFF_FFFE, 32'd1, 32'd5};
    send_row_vals();
  endtask

  // Count codes: zero, the top of the range, above it and the smallest.
  task automatic test_count_codes();
    write_top_count(4'd0);
    row_vals = {32'd9, 32'd4};
    send_row_vals();
    write_top_count(4'd8);
    row_vals = {32'd11, 32'd2};
    send_row_vals();
    write_top_count(4'd9);
    row_vals = {32'hFFFF_FFFF, 32'd0};
    send_row_vals();
    write_top_count(4'd15);
    row_vals = {32'd4, 32'd9, 32'd1, 32'd7, 32'd3, 32'd8, 32'd2, 32'd6, 32'd5};
    send_row_vals();
    write_top_count(4'd1);
    row_vals = {32'hFFFF_FFFF};
    send_row_vals();
  endtask

  // Random rows over several count settings.
  task automatic test_random_rows();
    logic [CFG_W-1:0] codes [6];
    int               p;
    codes = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd4, 4'd0};
    codes[5] = CFG_W'($urandom_range(0, 15));
    for (p = 0; p < 6; p++) begin
      write_top_count(codes[p]);
      send_random_rows(50);
    end
  endtask

  // The receiver holds off while short rows keep coming, so the row queue fills.
  task automatic test_receiver_hold();
    int j;
    write_top_count(4'd8);
    in_idle_en = 1'b0;
    hold_req   = 250;
    for (j = 0; j < 40; j++) begin
      send_item($urandom, j % 2 == 1);
    end
    in_idle_en = 1'b1;
  endtask

  // The sender stops until every beat is out, then resumes.
  task automatic test_sender_pause();
    write_top_count(CFG_W'($urandom_range(0, 15)));
    send_random_rows(20);
    wait_all_results();
    send_random_rows(20);
  endtask

  // Both sides at full rate.
  task automatic test_full_rate();
    write_top_count(4'd3);
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    send_random_rows(30);
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
  endtask

  // Receiver: random stalls between beats, plus long hold-offs on request.
  initial begin : receiver
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_pop <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_pop <= 1'b0;
        stall_left--;
      end else begin
        out_pop <= 1'b1;
        stall_left = gap_len(out_idle_en);
      end
    end
  end

  // Compare each beat taken from the block with the oldest prediction.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (ranked_q.size() == 0) begin
        want = '0;
        log_mismatch("unexpected beat", want, out_item);
      end else begin
        want = ranked_q.pop_front();
        if (out_item.ranked_value !== want.ranked_value ||
            out_item.run_last !== want.run_last) begin
          log_mismatch("mismatch", want, out_item);
        end
      end
    end
  end

  // Main sequence.
  initial begin : main_seq
    int i;
    for (i = 0; i < MAX_TOP; i++) best_vals[i] = '0;
    model_top_count = TOP_COUNT_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_rows();
    test_count_codes();
    test_random_rows();
    test_receiver_hold();
    test_sender_pause();
    test_full_rate();

    wait_all_results();
    repeat (20) @(posedge clk);
    if (error_count == 0 && ranked_q.size() == 0) begin
      $display("** row_top_k_selector: PASSED **");
    end else begin
      $display("** row_top_k_selector: FAILED **");
    end
    $finish;
  end

  // Watchdog.
  initial begin : watchdog
    #10_000_000;
    $display("** row_top_k_selector: FAILED **");
    $finish;
  end

endmodule
